### hw/rtl/dzea_pkg.sv
// Shared types and constants for the decimated zero-excluding averager.
// No dependencies; used by dzea_div, the top level and the verification files.
`timescale 1ns / 1ps

package dzea_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int SAMPLE_W = 16;
   localparam int INTERVAL_W = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 8;

   localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 8'd100;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 8'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### hw/rtl/dzea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dzea_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dzea_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on dzea_pkg for the status struct and the quotient width.
`timescale 1ns / 1ps

module dzea_div #(
   parameter int DVD_W = 20,
   parameter int DVS_W = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [DVD_W-1:0]                 dividend,
   input  logic [DVS_W-1:0]                 divisor,
   output dzea_pkg::div_status_type         status,
   output logic [dzea_pkg::SAMPLE_W-1:0]    quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  dq_ff, dq_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              take;

   always_comb begin
      trial = {rem_ff, dq_ff[DVD_W-1]};
      diff = trial - {1'b0, dvs_ff};
      take = (trial >= {1'b0, dvs_ff});

      dq_in = dq_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         dq_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in = {dq_ff[DVD_W-2:0], take};
         rem_in = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = dq_ff[dzea_pkg::SAMPLE_W-1:0];

endmodule

### hw/rtl/decimated_zero_excluding_averager_top.sv
// Top level of the decimated zero-excluding averager.
// Depends on dzea_pkg, dzea_ram and dzea_div.
`timescale 1ns / 1ps

// One beat in gives one beat out. Every sample_interval beats (while enabled) the
// sample is written into a DEPTH-entry ring buffer; each result carries the truncated
// average of the nonzero entries, or 0 with mostly_zero set when more than
// (DEPTH-1)/2 entries are zero. A beat that stores a sample goes through these steps
// from one accepted beat to the earliest next one: the buffer update (the RAM
// read is issued as the beat is taken), a check of the zero count that starts
// the divider, the bit-serial divider over 16+log2(DEPTH) dividend bits, a
// state that sees it finish, one that loads the output register and one back in idle.
// A beat that stores nothing skips the update; a mostly zero buffer skips the divider,
// and otherwise the divider's one bit per cycle sets the rate, as a new beat is taken
// only in idle. The next beat is taken while a finished result waits in the output
// register; a result still stalled there holds the following one in its last step. The
// buffer reads as zero after reset through per-entry valid bits, so no clearing pass
// is needed. Configuration writes are taken at any time and must come while idle.
module decimated_zero_excluding_averager_top #(
   parameter int DEPTH = dzea_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dzea_pkg::SAMPLE_W-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dzea_pkg::SAMPLE_W-1:0]       rsp_average,
   output logic                                rsp_stored,
   output logic                                rsp_mostly_zero,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dzea_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dzea_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SAMPLE_W = dzea_pkg::SAMPLE_W;
   localparam int INTERVAL_W = dzea_pkg::INTERVAL_W;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(DEPTH);
   localparam int ZERO_LIMIT = (DEPTH - 1) / 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_CHECK,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic                  enable_ff, enable_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [INTERVAL_W-1:0] countdown_ff, countdown_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [DEPTH-1:0]      entry_valid_ff, entry_valid_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]      zero_ff, zero_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic                  stored_ff, stored_in;
   logic                  mostly_ff, mostly_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_average_ff, rsp_average_in;
   logic                  rsp_stored_ff, rsp_stored_in;
   logic                  rsp_mostly_ff, rsp_mostly_in;

   logic                  req_take;
   logic                  store_now;
   logic                  ram_wr_en;
   logic [SAMPLE_W-1:0]   ram_rd_data;
   logic [SAMPLE_W-1:0]   old_entry;
   logic                  old_zero;
   logic                  new_zero;
   logic                  div_start;
   logic [CNT_W-1:0]      nonzero;
   dzea_pkg::div_status_type div_status;
   logic [SAMPLE_W-1:0]   div_quotient;
   logic                  out_free;

   dzea_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (req_take),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   dzea_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (nonzero),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign store_now = (countdown_ff == '0) && enable_ff;
   assign old_entry = entry_valid_ff[slot_ff] ? ram_rd_data : '0;
   assign old_zero = (old_entry == '0);
   assign new_zero = (sample_ff == '0);
   assign ram_wr_en = (state_ff == ST_UPDATE);
   assign nonzero = CNT_W'(DEPTH) - zero_ff;
   assign div_start = (state_ff == ST_CHECK) && !(zero_ff > CNT_W'(ZERO_LIMIT));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      enable_in = enable_ff;
      interval_in = interval_ff;
      countdown_in = countdown_ff;
      slot_in = slot_ff;
      entry_valid_in = entry_valid_ff;
      sum_in = sum_ff;
      zero_in = zero_ff;
      sample_in = sample_ff;
      stored_in = stored_ff;
      mostly_in = mostly_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_average_in = rsp_average_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_mostly_in = rsp_mostly_ff;

      if (csr_valid) begin
         case (csr_index)
            dzea_pkg::CSR_ENABLE: enable_in = csr_wdata[0];
            dzea_pkg::CSR_INTERVAL: interval_in = csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_sample;
               stored_in = store_now;
               if (store_now) begin
                  countdown_in = (interval_ff == '0) ? '0 : interval_ff - INTERVAL_W'(1);
                  state_in = ST_UPDATE;
               end else begin
                  countdown_in = (countdown_ff == '0) ? '0 : countdown_ff - INTERVAL_W'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_UPDATE: begin
            sum_in = sum_ff - SUM_W'(old_entry) + SUM_W'(sample_ff);
            zero_in = zero_ff - CNT_W'(old_zero) + CNT_W'(new_zero);
            entry_valid_in[slot_ff] = 1'b1;
            slot_in = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            mostly_in = (zero_ff > CNT_W'(ZERO_LIMIT));
            state_in = mostly_in ? ST_DONE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_average_in = mostly_ff ? '0 : div_quotient;
               rsp_stored_in = stored_ff;
               rsp_mostly_in = mostly_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         enable_ff <= 1'b1;
         interval_ff <= dzea_pkg::RESET_INTERVAL;
         countdown_ff <= '0;
         slot_ff <= '0;
         entry_valid_ff <= '0;
         sum_ff <= '0;
         zero_ff <= CNT_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         enable_ff <= enable_in;
         interval_ff <= interval_in;
         countdown_ff <= countdown_in;
         slot_ff <= slot_in;
         entry_valid_ff <= entry_valid_in;
         sum_ff <= sum_in;
         zero_ff <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      stored_ff <= stored_in;
      mostly_ff <= mostly_in;
      rsp_average_ff <= rsp_average_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_mostly_ff <= rsp_mostly_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_stored = rsp_stored_ff;
   assign rsp_mostly_zero = rsp_mostly_ff;

   a_zero_count_bound : assert property (@(posedge clock) disable iff (reset)
      zero_ff <= CNT_W'(DEPTH))
      else $error("zero entry count above buffer depth");

   a_empty_sum : assert property (@(posedge clock) disable iff (reset)
      (zero_ff == CNT_W'(DEPTH)) |-> (sum_ff == '0))
      else $error("running sum nonzero with all entries zero");

   a_mostly_avg : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mostly_ff) |-> (rsp_average_ff == '0))
      else $error("nonzero average on a mostly zero beat");

   a_take_busy : assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE) && !div_status.busy)
      else $error("beat taken while block not idle");

endmodule

### verif/dzea_checker.sv
// Checker for the decimated zero-excluding averager: watches the sample, result and
// register channels, predicts every result beat and compares it field by field.
// Depends on dzea_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module dzea_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [dzea_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [dzea_pkg::SAMPLE_W-1:0]    rsp_average,
   input  logic                             rsp_stored,
   input  logic                             rsp_mostly_zero,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [dzea_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dzea_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               pending
);

   localparam int DEPTH = dzea_pkg::DEPTH_DEFAULT;
   localparam int SAMPLE_W = dzea_pkg::SAMPLE_W;
   localparam int INTERVAL_W = dzea_pkg::INTERVAL_W;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int SUM_W = SAMPLE_W + SLOT_W;
   localparam int ZERO_LIMIT = (DEPTH - 1) / 2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic                stored;
      logic                mostly_zero;
   } tick_result_type;

   logic [SAMPLE_W-1:0]   ring [DEPTH];
   logic [SLOT_W-1:0]     write_slot;
   logic [INTERVAL_W-1:0] countdown;
   logic [SUM_W-1:0]      running_sum;
   int                    zero_entries;
   logic                  enable;
   logic [INTERVAL_W-1:0] interval;
   tick_result_type       expected_ticks [$];
   int                    fails = 0;

   task automatic clear_averager();
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      write_slot = '0;
      countdown = '0;
      running_sum = '0;
      zero_entries = DEPTH;
      enable = 1'b1;
      interval = dzea_pkg::RESET_INTERVAL;
   endtask

   task automatic apply_register(input logic [dzea_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [dzea_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         dzea_pkg::CSR_ENABLE: begin
            enable = val[0];
         end
         dzea_pkg::CSR_INTERVAL: begin
            interval = val[INTERVAL_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic step_averager(input logic [SAMPLE_W-1:0] v, output tick_result_type r);
      logic [SAMPLE_W-1:0] old;
      r = '0;
      if (countdown == 0 && enable) begin
         old = ring[write_slot];
         running_sum = running_sum - old + v;
         if (old == 0) zero_entries--;
         if (v == 0) zero_entries++;
         ring[write_slot] = v;
         write_slot = (write_slot == SLOT_W'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
         countdown = interval;
         r.stored = 1'b1;
      end
      if (countdown != 0) countdown = countdown - 1'b1;
      if (zero_entries > ZERO_LIMIT) begin
         r.mostly_zero = 1'b1;
      end else begin
         r.average = SAMPLE_W'(running_sum / (DEPTH - zero_entries));
      end
   endtask

   always @(posedge clock) begin : watch
      tick_result_type want;
      if (reset) begin
         clear_averager();
         expected_ticks.delete();
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         // the result beat belongs to an older sample, so retire it first
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               $error("result beat with no sample pending: average %0d", rsp_average);
               fails++;
            end else begin
               want = expected_ticks.pop_front();
               if (want.average !== rsp_average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_average);
                  fails++;
               end
               if (want.stored !== rsp_stored) begin
                  $error("stored: expected %0b, got %0b", want.stored, rsp_stored);
                  fails++;
               end
               if (want.mostly_zero !== rsp_mostly_zero) begin
                  $error("mostly_zero: expected %0b, got %0b", want.mostly_zero,
                         rsp_mostly_zero);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            step_averager(req_sample, want);
            expected_ticks.push_back(want);
         end
      end
      pending = expected_ticks.size();
      fail_count = fails;
   end

endmodule

### verif/tb.sv
// Testbench top for the decimated zero-excluding averager: drives samples, register
// writes and result stalls in several idling phases and gives the verdict.
// Depends on dzea_pkg, the block's RTL and dzea_checker.
`timescale 1ns / 1ps

module tb;

   localparam int SAMPLE_W = dzea_pkg::SAMPLE_W;
   localparam int INTERVAL_W = dzea_pkg::INTERVAL_W;
   localparam int CSR_INDEX_W = dzea_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W = dzea_pkg::CSR_DATA_W;
   localparam int QUIET_LIMIT = 2000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW = dzea_pkg::CSR_INTERVAL + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HIGH = '1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_average;
   logic                   rsp_stored;
   logic                   rsp_mostly_zero;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     fail_count;
   int                     pending;
   int                     idle_pct = 0;
   int                     stall_pct = 0;
   int                     zero_pct = 25;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   decimated_zero_excluding_averager_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .rsp_stored      (rsp_stored),
      .rsp_mostly_zero (rsp_mostly_zero),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   dzea_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_average     (rsp_average),
      .rsp_stored      (rsp_stored),
      .rsp_mostly_zero (rsp_mostly_zero),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_sample(input logic [SAMPLE_W-1:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val, input bit last_write);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      if (last_write) csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic en, input logic [INTERVAL_W-1:0] interval);
      // upper bits of the enable write are dropped by the block
      write_register(dzea_pkg::CSR_ENABLE, {7'($urandom), en}, 1'b0);
      write_register(dzea_pkg::CSR_INTERVAL, interval, 1'b1);
   endtask

   function automatic logic [INTERVAL_W-1:0] pick_interval();
      case ($urandom_range(5))
         0: pick_interval = '0;
         1: pick_interval = 8'd1;
         2, 3: pick_interval = INTERVAL_W'($urandom_range(2, 4));
         default: pick_interval = INTERVAL_W'($urandom_range(5, 12));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int r;
      r = $urandom_range(99);
      if (r < zero_pct) random_sample = '0;
      else if (r < zero_pct + 10) random_sample = '1;
      else if (r < zero_pct + 20) random_sample = SAMPLE_W'($urandom_range(1, 15));
      else random_sample = SAMPLE_W'($urandom);
   endfunction

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("tb failed");
      $finish;
   end

   initial begin : stimulus
      int n;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero interval stores every beat; unused indexes are ignored
      write_register(dzea_pkg::CSR_INTERVAL, '0, 1'b0);
      write_register(dzea_pkg::CSR_ENABLE, 8'hFF, 1'b0);
      write_register(CSR_UNUSED_LOW, 8'h55, 1'b0);
      write_register(CSR_UNUSED_HIGH, 8'hA5, 1'b1);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      repeat (11) send_sample(16'hFFFF);
      send_sample(16'h0000);
      drain_results();

      write_register(dzea_pkg::CSR_INTERVAL, 8'd2, 1'b1);
      send_sample(16'd3);
      send_sample(16'd4);
      send_sample(16'd5);
      drain_results();
      // bit 0 clear: disabled, countdown runs down and holds
      write_register(dzea_pkg::CSR_ENABLE, 8'hFE, 1'b1);
      send_sample(16'd6);
      send_sample(16'd7);
      drain_results();
      write_register(dzea_pkg::CSR_ENABLE, 8'h01, 1'b1);
      send_sample(16'd8);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 86;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 86;
            end
            default: begin
               idle_pct = 13;
               stall_pct = 13;
            end
         endcase
         for (int blk = 0; blk < 5; blk++) begin
            configure($urandom_range(5) != 0, pick_interval());
            case ($urandom_range(2))
               0: zero_pct = 5;
               1: zero_pct = 30;
               default: zero_pct = 60;
            endcase
            n = $urandom_range(30, 46);
            repeat (n) send_sample(random_sample());
            drain_results();
         end
      end

      // largest interval: one store, then a long countdown
      idle_pct = 13;
      stall_pct = 13;
      configure(1'b1, '1);
      repeat (20) send_sample(random_sample());
      drain_results();

      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule
